### sv/dbc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the density clustering block
// used by dbc_ctrl, dbc_datapath and density_clustering_2d; no dependencies
package dbc_pkg;

	// default sizes
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;

	// fixed field widths
	localparam int MIN_W   = 6;
	localparam int RAD_W   = 16;
	localparam int NUM_W   = 6;
	localparam int CFG_W   = 16;
	localparam int CFG_IW  = 1;

	// register indexes and reset values
	localparam logic [CFG_IW-1:0] REG_MIN_NEIGHBORS = 1'd0;
	localparam logic [CFG_IW-1:0] REG_RADIUS        = 1'd1;
	localparam logic [MIN_W-1:0]  MIN_RESET         = 6'd4;
	localparam logic [RAD_W-1:0]  RAD_RESET         = 16'd256;

	// commands from the controller to the datapath
	typedef struct packed {
		logic store_we;
		logic rd_a;
		logic rd_b;
		logic row_clr;
		logic pair_v;
		logic row_wr;
		logic adj_rd;
		logic cnt_rd;
		logic emit_move;
		logic emit_load;
		logic set_exp;
		logic mark_cend;
		logic mark_aend;
		logic load_marker;
		logic clust_inc;
		logic run_clr;
	} dbc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_free;
		logic pend_v;
		logic core;
		logic adj_bit;
		logic clustered_a;
		logic expanded_a;
	} dbc_sts_t;

endpackage

### sv/dbc_datapath.sv
`timescale 1ns / 1ps
// datapath: point store, distance pipeline, adjacency and count memories,
// flags, pending result and output register; uses dbc_pkg
module dbc_datapath #(
	parameter int MAX_POINTS = dbc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = dbc_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [dbc_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [dbc_pkg::CFG_W-1:0]           cfg_data,
	input  dbc_pkg::dbc_cmd_t                   cmd,
	input  logic [$clog2(MAX_POINTS)-1:0]       addr_a,
	input  logic [$clog2(MAX_POINTS)-1:0]       addr_b,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	output dbc_pkg::dbc_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dbc_pkg::NUM_W-1:0]           cluster_number,
	output logic [dbc_pkg::NUM_W-1:0]           point_index,
	output logic signed [COORD_BITS-1:0]        out_x,
	output logic signed [COORD_BITS-1:0]        out_y,
	output logic                                cluster_end,
	output logic                                all_end,
	output logic                                none_found
);

	localparam int IW   = $clog2(MAX_POINTS);
	localparam int CW   = IW + 1;
	localparam int CB   = COORD_BITS;
	localparam int RW   = dbc_pkg::RAD_W;
	localparam int SQW  = 2 * RW;
	localparam int CMPW = (CB + 1 > RW) ? CB + 1 : RW;
	localparam int NCW  = (CW > dbc_pkg::MIN_W) ? CW : dbc_pkg::MIN_W;

	// configuration registers
	logic [dbc_pkg::MIN_W-1:0] min_q;
	logic [RW-1:0]             rad_q;
	logic [SQW-1:0]            r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= dbc_pkg::MIN_RESET;
			rad_q <= dbc_pkg::RAD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				dbc_pkg::REG_MIN_NEIGHBORS: min_q <= cfg_data[dbc_pkg::MIN_W-1:0];
				dbc_pkg::REG_RADIUS:        rad_q <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// squared radius, settles while idle
	always_ff @(posedge clk) begin
		r2_q <= rad_q * rad_q;
	end

	// point store, one write and two registered reads
	logic signed [CB-1:0] x_mem [MAX_POINTS];
	logic signed [CB-1:0] y_mem [MAX_POINTS];
	logic signed [CB-1:0] xa_q, ya_q, xb_q, yb_q;

	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			x_mem[addr_a] <= point_x;
			y_mem[addr_a] <= point_y;
		end
		if (cmd.rd_a) begin
			xa_q <= x_mem[addr_a];
			ya_q <= y_mem[addr_a];
		end
		if (cmd.rd_b) begin
			xb_q <= x_mem[addr_b];
			yb_q <= y_mem[addr_b];
		end
	end

	// stage 1: differences, range check and squares
	logic          v_s1, self_s1;
	logic [IW-1:0] j_s1;
	logic signed [CB:0] dx, dy;
	logic [CB:0]        adx, ady;
	logic [CMPW-1:0]    adx_e, ady_e, rad_e;
	logic               far;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.pair_v;
		end
	end

	always_ff @(posedge clk) begin
		j_s1    <= addr_b;
		self_s1 <= (addr_a == addr_b);
	end

	always_comb begin
		dx    = {xa_q[CB-1], xa_q} - {xb_q[CB-1], xb_q};
		dy    = {ya_q[CB-1], ya_q} - {yb_q[CB-1], yb_q};
		adx   = dx[CB] ? (~dx + 1'b1) : dx;
		ady   = dy[CB] ? (~dy + 1'b1) : dy;
		adx_e = CMPW'(adx);
		ady_e = CMPW'(ady);
		rad_e = CMPW'(rad_q);
		far   = (adx_e > rad_e) || (ady_e > rad_e);
	end

	// stage 2: sum and compare, neighbor row build
	logic           v_s2, self_s2, far_s2;
	logic [IW-1:0]  j_s2;
	logic [SQW-1:0] dx2_s2, dy2_s2;
	logic           hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		j_s2    <= j_s1;
		self_s2 <= self_s1;
		far_s2  <= far;
		dx2_s2  <= adx_e[RW-1:0] * adx_e[RW-1:0];
		dy2_s2  <= ady_e[RW-1:0] * ady_e[RW-1:0];
	end

	assign hit = v_s2 && !far_s2 && !self_s2 &&
		(({1'b0, dx2_s2} + {1'b0, dy2_s2}) <= {1'b0, r2_q});

	logic [MAX_POINTS-1:0] row_q;
	logic [CW-1:0]         rcnt_q;

	always_ff @(posedge clk) begin
		if (cmd.row_clr) begin
			row_q  <= '0;
			rcnt_q <= '0;
		end else if (hit) begin
			row_q[j_s2] <= 1'b1;
			rcnt_q      <= rcnt_q + 1'b1;
		end
	end

	// adjacency and neighbor count memories
	logic [MAX_POINTS-1:0] adj_mem [MAX_POINTS];
	logic [CW-1:0]         cnt_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] adj_rd_q;
	logic [CW-1:0]         cnt_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			adj_mem[addr_a] <= row_q;
			cnt_mem[addr_a] <= rcnt_q;
		end
		if (cmd.adj_rd) begin
			adj_rd_q <= adj_mem[addr_a];
		end
		if (cmd.cnt_rd) begin
			cnt_rd_q <= cnt_mem[addr_a];
		end
	end

	// per point flags and cluster count
	logic [MAX_POINTS-1:0]     clustered_q, expanded_q;
	logic [dbc_pkg::NUM_W-1:0] clu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clustered_q <= '0;
			expanded_q  <= '0;
			clu_q       <= '0;
		end else if (cmd.run_clr) begin
			clustered_q <= '0;
			expanded_q  <= '0;
			clu_q       <= '0;
		end else begin
			if (cmd.emit_load) begin
				clustered_q[addr_a] <= 1'b1;
			end
			if (cmd.set_exp) begin
				expanded_q[addr_a] <= 1'b1;
			end
			if (cmd.clust_inc) begin
				clu_q <= clu_q + 1'b1;
			end
		end
	end

	// pending result, its end marks are set after the fact
	logic                      pv_q;
	logic [dbc_pkg::NUM_W-1:0] pnum_q, pidx_q;
	logic signed [CB-1:0]      px_q, py_q;
	logic                      pce_q, pae_q, pnone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (cmd.emit_load || cmd.load_marker) begin
			pv_q <= 1'b1;
		end else if (cmd.emit_move) begin
			pv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			pnum_q  <= clu_q;
			pidx_q  <= dbc_pkg::NUM_W'(addr_a);
			px_q    <= xa_q;
			py_q    <= ya_q;
			pce_q   <= 1'b0;
			pae_q   <= 1'b0;
			pnone_q <= 1'b0;
		end else if (cmd.load_marker) begin
			pnum_q  <= '0;
			pidx_q  <= '0;
			px_q    <= '0;
			py_q    <= '0;
			pce_q   <= 1'b0;
			pae_q   <= 1'b1;
			pnone_q <= 1'b1;
		end else begin
			if (cmd.mark_cend) begin
				pce_q <= 1'b1;
			end
			if (cmd.mark_aend) begin
				pae_q <= 1'b1;
			end
		end
	end

	// output register
	logic ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit_move) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_move) begin
			cluster_number <= pnum_q;
			point_index    <= pidx_q;
			out_x          <= px_q;
			out_y          <= py_q;
			cluster_end    <= pce_q;
			all_end        <= pae_q;
			none_found     <= pnone_q;
		end
	end

	assign out_valid = ov_q;

	// status
	always_comb begin
		sts.out_free    = !ov_q || out_ready;
		sts.pend_v      = pv_q;
		sts.core        = NCW'(cnt_rd_q) >= NCW'(min_q);
		sts.adj_bit     = adj_rd_q[addr_b];
		sts.clustered_a = clustered_q[addr_a];
		sts.expanded_a  = expanded_q[addr_a];
	end

`ifndef NO_ASSERTIONS
	a_mark_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mark_cend || cmd.mark_aend) |-> pv_q)
		else $error("end mark without a pending result");
	a_move_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_move |-> (!ov_q || out_ready))
		else $error("output register overwritten while stalled");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !clustered_q[addr_a])
		else $error("point emitted twice");
`endif

endmodule

### sv/dbc_ctrl.sv
`timescale 1ns / 1ps
// controller: load, distance sweep and depth-first walk sequencing,
// loop counters and the walk stack memory; uses dbc_pkg
module dbc_ctrl #(
	parameter int MAX_POINTS = dbc_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          last_point,
	input  dbc_pkg::dbc_sts_t             sts,
	output dbc_pkg::dbc_cmd_t             cmd,
	output logic [$clog2(MAX_POINTS)-1:0] addr_a,
	output logic [$clog2(MAX_POINTS)-1:0] addr_b
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = IW + 1;
	localparam int SW = IW + CW;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DIST  = 5'd1;
	localparam logic [4:0] S_DR0   = 5'd2;
	localparam logic [4:0] S_DR1   = 5'd3;
	localparam logic [4:0] S_WR    = 5'd4;
	localparam logic [4:0] S_WOUT  = 5'd5;
	localparam logic [4:0] S_WOCHK = 5'd6;
	localparam logic [4:0] S_EMIT  = 5'd7;
	localparam logic [4:0] S_EMIT2 = 5'd8;
	localparam logic [4:0] S_ROWRD = 5'd9;
	localparam logic [4:0] S_SCAN  = 5'd10;
	localparam logic [4:0] S_CHK   = 5'd11;
	localparam logic [4:0] S_PUSH  = 5'd12;
	localparam logic [4:0] S_POP   = 5'd13;
	localparam logic [4:0] S_POP2  = 5'd14;
	localparam logic [4:0] S_FIN   = 5'd15;
	localparam logic [4:0] S_FLUSH = 5'd16;

	logic [4:0]    st_q, st_d;
	logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, q_q, q_d, sp_q, sp_d;
	logic [IW-1:0] c_q, c_d, p_q, p_d;
	logic          start_q, start_d, push_q, push_d, found_q, found_d;
	logic          stk_we, stk_re;

	// walk stack: parent center and its resume index
	logic [SW-1:0] stk_mem [MAX_POINTS];
	logic [SW-1:0] stk_rd_q;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[sp_q[IW-1:0]] <= {c_q, q_q + 1'b1};
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[sp_q[IW-1:0] - 1'b1];
		end
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			q_q     <= '0;
			sp_q    <= '0;
			c_q     <= '0;
			p_q     <= '0;
			start_q <= 1'b0;
			push_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			n_q     <= n_d;
			i_q     <= i_d;
			j_q     <= j_d;
			q_q     <= q_d;
			sp_q    <= sp_d;
			c_q     <= c_d;
			p_q     <= p_d;
			start_q <= start_d;
			push_q  <= push_d;
			found_q <= found_d;
		end
	end

	// next state and commands
	always_comb begin
		st_d     = st_q;
		n_d      = n_q;
		i_d      = i_q;
		j_d      = j_q;
		q_d      = q_q;
		sp_d     = sp_q;
		c_d      = c_q;
		p_d      = p_q;
		start_d  = start_q;
		push_d   = push_q;
		found_d  = found_q;
		cmd      = '0;
		addr_a   = '0;
		addr_b   = '0;
		in_ready = 1'b0;
		stk_we   = 1'b0;
		stk_re   = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.row_clr = 1'b1;
				addr_a      = n_q[IW-1:0];
				if (in_valid) begin
					if (n_q < CW'(MAX_POINTS)) begin
						cmd.store_we = 1'b1;
						n_d          = n_q + 1'b1;
					end
					if (last_point) begin
						i_d  = '0;
						j_d  = '0;
						st_d = S_DIST;
					end
				end
			end
			S_DIST: begin
				addr_a     = i_q[IW-1:0];
				addr_b     = j_q[IW-1:0];
				cmd.rd_a   = 1'b1;
				cmd.rd_b   = 1'b1;
				cmd.pair_v = 1'b1;
				if (j_q == n_q - 1'b1) begin
					st_d = S_DR0;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_DR0: st_d = S_DR1;
			S_DR1: st_d = S_WR;
			S_WR: begin
				addr_a      = i_q[IW-1:0];
				cmd.row_wr  = 1'b1;
				cmd.row_clr = 1'b1;
				j_d         = '0;
				if (i_q == n_q - 1'b1) begin
					i_d     = '0;
					found_d = 1'b0;
					st_d    = S_WOUT;
				end else begin
					i_d  = i_q + 1'b1;
					st_d = S_DIST;
				end
			end
			S_WOUT: begin
				addr_a = i_q[IW-1:0];
				if (i_q == n_q) begin
					st_d = S_FIN;
				end else begin
					cmd.cnt_rd = 1'b1;
					st_d       = S_WOCHK;
				end
			end
			S_WOCHK: begin
				addr_a = i_q[IW-1:0];
				if (!sts.clustered_a && sts.core) begin
					p_d     = i_q[IW-1:0];
					start_d = 1'b1;
					st_d    = S_EMIT;
				end else begin
					i_d  = i_q + 1'b1;
					st_d = S_WOUT;
				end
			end
			S_EMIT: begin
				addr_a = p_q;
				if (!sts.pend_v || sts.out_free) begin
					cmd.emit_move = sts.pend_v;
					cmd.rd_a      = 1'b1;
					st_d          = S_EMIT2;
				end
			end
			S_EMIT2: begin
				addr_a        = p_q;
				cmd.emit_load = 1'b1;
				if (start_q) begin
					cmd.set_exp = 1'b1;
					c_d         = p_q;
					q_d         = '0;
					sp_d        = '0;
					st_d        = S_ROWRD;
				end else begin
					st_d = S_PUSH;
				end
			end
			S_ROWRD: begin
				addr_a     = c_q;
				cmd.adj_rd = 1'b1;
				st_d       = S_SCAN;
			end
			S_SCAN: begin
				addr_a = q_q[IW-1:0];
				addr_b = q_q[IW-1:0];
				if (q_q == n_q) begin
					st_d = S_POP;
				end else if (!sts.adj_bit) begin
					q_d = q_q + 1'b1;
				end else begin
					cmd.cnt_rd = 1'b1;
					st_d       = S_CHK;
				end
			end
			S_CHK: begin
				addr_a = q_q[IW-1:0];
				push_d = !sts.expanded_a && sts.core;
				p_d    = q_q[IW-1:0];
				if (!sts.clustered_a) begin
					start_d = 1'b0;
					st_d    = S_EMIT;
				end else begin
					st_d = S_PUSH;
				end
			end
			S_PUSH: begin
				addr_a = q_q[IW-1:0];
				if (push_q) begin
					stk_we      = 1'b1;
					cmd.set_exp = 1'b1;
					sp_d        = sp_q + 1'b1;
					c_d         = q_q[IW-1:0];
					q_d         = '0;
					st_d        = S_ROWRD;
				end else begin
					q_d  = q_q + 1'b1;
					st_d = S_SCAN;
				end
			end
			S_POP: begin
				if (sp_q == '0) begin
					cmd.mark_cend = 1'b1;
					cmd.clust_inc = 1'b1;
					found_d       = 1'b1;
					i_d           = i_q + 1'b1;
					st_d          = S_WOUT;
				end else begin
					stk_re = 1'b1;
					st_d   = S_POP2;
				end
			end
			S_POP2: begin
				c_d  = stk_rd_q[SW-1:CW];
				q_d  = stk_rd_q[CW-1:0];
				sp_d = sp_q - 1'b1;
				st_d = S_ROWRD;
			end
			S_FIN: begin
				if (found_q) begin
					cmd.mark_aend = 1'b1;
				end else begin
					cmd.load_marker = 1'b1;
				end
				st_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.emit_move = 1'b1;
					cmd.run_clr   = 1'b1;
					n_d           = '0;
					st_d          = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_PUSH && push_q) |-> (sp_q < CW'(MAX_POINTS)))
		else $error("walk stack overflow");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN) |-> (q_q <= n_q))
		else $error("scan index past point count");
`endif

endmodule

### sv/density_clustering_2d.sv
`timescale 1ns / 1ps
// top level of the 2d density clustering block
// instantiates dbc_ctrl and dbc_datapath; uses dbc_pkg
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_ready  | point_x, point_y, last_point
// output   | out_valid / out_ready| cluster_number, point_index, out_x, out_y,
//          |                      | cluster_end, all_end, none_found
// config   | cfg_write            | cfg_index, cfg_data
//
// a point without last_point is taken at once while idle
// the last point starts a distance sweep, run by one distance pipeline fed
// from the two read ports of the point store
// the walk then scans each center's adjacency row one index a cycle,
// pausing at each set bit to handle that neighbor
// no clearing pass after reset; in_ready is low from the last point until
// the final result enters the output register, and a stalled output
// holds the walk at its next emission
module density_clustering_2d #(
	parameter int MAX_POINTS = dbc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = dbc_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [dbc_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [dbc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dbc_pkg::NUM_W-1:0]     cluster_number,
	output logic [dbc_pkg::NUM_W-1:0]     point_index,
	output logic signed [COORD_BITS-1:0]  out_x,
	output logic signed [COORD_BITS-1:0]  out_y,
	output logic                          cluster_end,
	output logic                          all_end,
	output logic                          none_found
);

	localparam int IW = $clog2(MAX_POINTS);

	dbc_pkg::dbc_cmd_t cmd;
	dbc_pkg::dbc_sts_t sts;
	logic [IW-1:0]     addr_a, addr_b;

	// sequencing
	dbc_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_point(last_point),
		.sts       (sts),
		.cmd       (cmd),
		.addr_a    (addr_a),
		.addr_b    (addr_b)
	);

	// storage and arithmetic
	dbc_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.addr_a        (addr_a),
		.addr_b        (addr_b),
		.point_x       (point_x),
		.point_y       (point_y),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cluster_number(cluster_number),
		.point_index   (point_index),
		.out_x         (out_x),
		.out_y         (out_y),
		.cluster_end   (cluster_end),
		.all_end       (all_end),
		.none_found    (none_found)
	);

endmodule

### dv/dbc_checker.sv
`timescale 1ns / 1ps
// checker for the density clustering block: watches both channels and the config port,
// predicts the emitted points of each cloud and compares them; uses dbc_pkg
module dbc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [dbc_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [dbc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [15:0]            point_x,
	input  logic signed [15:0]            point_y,
	input  logic                          last_point,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [5:0]                    cluster_number,
	input  logic [5:0]                    point_index,
	input  logic signed [15:0]            out_x,
	input  logic signed [15:0]            out_y,
	input  logic                          cluster_end,
	input  logic                          all_end,
	input  logic                          none_found,
	output int                            fail_count,
	output int                            pending
);

	localparam int NPTS = 64;

	typedef struct packed {
		logic [5:0]         cnum;
		logic [5:0]         pidx;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               cend;
		logic               aend;
		logic               nf;
	} emitted_t;

	emitted_t cluster_q[$];
	logic [5:0] min_nb;
	logic [15:0] rad;
	logic signed [15:0] xs [NPTS];
	logic signed [15:0] ys [NPTS];
	int loaded;

	assign pending = cluster_q.size();

	// neighbor test with exact squared distance
	function automatic bit is_near(int a, int b);
		longint dx, dy;
		dx = longint'(xs[a]) - longint'(xs[b]);
		dy = longint'(ys[a]) - longint'(ys[b]);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx > rad || dy > rad) return 0;
		return dx * dx + dy * dy <= longint'(rad) * longint'(rad);
	endfunction

	// cluster the held cloud and queue the emitted points
	task automatic cluster_cloud();
		bit adj [NPTS][NPTS];
		int ncnt [NPTS];
		bit clus [NPTS];
		bit expd [NPTS];
		int stc [NPTS];
		int stn [NPTS];
		int sp, k, c, q, cid;
		emitted_t e;
		k = 0;
		cid = 0;
		for (int i = 0; i < loaded; i++) begin
			ncnt[i] = 0;
			clus[i] = 0;
			expd[i] = 0;
			for (int j = 0; j < loaded; j++) begin
				adj[i][j] = (i != j) && is_near(i, j);
				if (adj[i][j]) ncnt[i]++;
			end
		end
		for (int i = 0; i < loaded; i++) begin
			if (clus[i] || ncnt[i] < min_nb) continue;
			e = '{cnum: cid[5:0], pidx: i[5:0], x: xs[i], y: ys[i], default: 0};
			cluster_q.insert(cluster_q.size(), e);
			clus[i] = 1;
			k++;
			expd[i] = 1;
			stc[0] = i;
			stn[0] = 0;
			sp = 1;
			while (sp > 0) begin
				c = stc[sp-1];
				q = stn[sp-1];
				while (q < loaded && !adj[c][q]) q++;
				if (q >= loaded) begin
					sp--;
					continue;
				end
				stn[sp-1] = q + 1;
				if (!clus[q] && k < NPTS) begin
					e = '{cnum: cid[5:0], pidx: q[5:0], x: xs[q], y: ys[q], default: 0};
					cluster_q.insert(cluster_q.size(), e);
					clus[q] = 1;
					k++;
				end
				if (!expd[q] && ncnt[q] >= min_nb && sp < NPTS) begin
					expd[q] = 1;
					stc[sp] = q;
					stn[sp] = 0;
					sp++;
				end
			end
			cluster_q[cluster_q.size()-1].cend = 1;
			cid++;
		end
		if (k == 0) begin
			e = '{aend: 1, nf: 1, default: 0};
			cluster_q.insert(cluster_q.size(), e);
		end else begin
			cluster_q[cluster_q.size()-1].aend = 1;
		end
		loaded = 0;
	endtask

	// field compare against the oldest expectation
	task automatic compare_result();
		emitted_t e;
		if (cluster_q.size() == 0) begin
			$error("unexpected result: point_index %0d", point_index);
			fail_count++;
			return;
		end
		e = cluster_q.pop_front();
		if (cluster_number !== e.cnum) begin
			$error("cluster_number exp %0d got %0d", e.cnum, cluster_number); fail_count++;
		end
		if (point_index !== e.pidx) begin
			$error("point_index exp %0d got %0d", e.pidx, point_index); fail_count++;
		end
		if (out_x !== e.x) begin
			$error("out_x exp %0d got %0d", e.x, out_x); fail_count++;
		end
		if (out_y !== e.y) begin
			$error("out_y exp %0d got %0d", e.y, out_y); fail_count++;
		end
		if (cluster_end !== e.cend) begin
			$error("cluster_end exp %0b got %0b", e.cend, cluster_end); fail_count++;
		end
		if (all_end !== e.aend) begin
			$error("all_end exp %0b got %0b", e.aend, all_end); fail_count++;
		end
		if (none_found !== e.nf) begin
			$error("none_found exp %0b got %0b", e.nf, none_found); fail_count++;
		end
	endtask

	// watch config, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_nb = dbc_pkg::MIN_RESET;
			rad = dbc_pkg::RAD_RESET;
			loaded = 0;
			fail_count = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == dbc_pkg::REG_MIN_NEIGHBORS)
					min_nb = cfg_data[dbc_pkg::MIN_W-1:0];
				else if (cfg_index == dbc_pkg::REG_RADIUS)
					rad = cfg_data[dbc_pkg::RAD_W-1:0];
			end
			if (out_valid && out_ready) compare_result();
			if (in_valid && in_ready) begin
				if (loaded < NPTS) begin
					xs[loaded] = point_x;
					ys[loaded] = point_y;
					loaded++;
				end
				if (last_point) cluster_cloud();
			end
		end
	end
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// top of the density clustering testbench: clock, reset, point clouds, config phases
// and verdict; instantiates density_clustering_2d and dbc_checker, uses dbc_pkg
module testbench;

	localparam int WATCH_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [dbc_pkg::CFG_IW-1:0] cfg_index;
	logic [dbc_pkg::CFG_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [15:0] point_x, point_y;
	logic last_point;
	logic out_valid, out_ready;
	logic [5:0] cluster_number, point_index;
	logic signed [15:0] out_x, out_y;
	logic cluster_end, all_end, none_found;
	int fail_count, pending;
	int idle_cycles = 0;
	int points_sent;
	logic signed [15:0] cx, cy;

	density_clustering_2d i_dut (.*);

	dbc_checker i_checker (.*);

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles with no request and no result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// random output stall before each result, sometimes none
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
			if (gap != 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// one register write, then cfg_write is lowered and the bus left quiet
	task automatic write_reg(input logic [dbc_pkg::CFG_IW-1:0] idx, input int val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val[dbc_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_write <= 0;
		@(posedge clk);
	endtask

	// one point request with random lead-in gap
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic last);
		int gap;
		gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		points_sent++;
	endtask

	// wait for the cloud's results, then the tail of the sweep
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random cloud: blobs around a few centers, plus scattered noise
	task automatic random_cloud(input int n, input int spread);
		logic signed [15:0] px, py;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(7) == 0) begin
				px = 16'($urandom);
				py = 16'($urandom);
			end else begin
				if ($urandom_range(5) == 0) begin
					cx = 16'($urandom);
					cy = 16'($urandom);
				end
				px = 16'(cx + $signed($urandom_range(2 * spread)) - spread);
				py = 16'(cy + $signed($urandom_range(2 * spread)) - spread);
			end
			send_point(px, py, i == n - 1);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		point_x = 0;
		point_y = 0;
		last_point = 0;
		points_sent = 0;
		cx = 0;
		cy = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: lone last point, no cluster at reset setting
		send_point(16'sh7fff, -16'sh8000, 1'b1);
		drain();
		// extremes with max radius and zero threshold: every point is core
		write_reg(dbc_pkg::REG_RADIUS, 16'hffff);
		write_reg(dbc_pkg::REG_MIN_NEIGHBORS, 0);
		send_point(16'sh7fff, 16'sh7fff, 1'b0);
		send_point(-16'sh8000, -16'sh8000, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(-16'sd1, 16'sd1, 1'b1);
		drain();
		// radius zero: only coincident points touch
		write_reg(dbc_pkg::REG_RADIUS, 0);
		write_reg(dbc_pkg::REG_MIN_NEIGHBORS, 1);
		send_point(16'sd5, 16'sd5, 1'b0);
		send_point(16'sd5, 16'sd5, 1'b0);
		send_point(16'sd6, 16'sd5, 1'b0);
		send_point(16'sd6, 16'sd5, 1'b1);
		drain();
		// threshold at top: nothing is core
		write_reg(dbc_pkg::REG_MIN_NEIGHBORS, 63);
		write_reg(dbc_pkg::REG_RADIUS, 16'hffff);
		for (int i = 0; i < 4; i++) send_point(16'(i), 16'(i), i == 3);
		drain();
		// store overflow: 66 points, two dropped, everything one cluster
		write_reg(dbc_pkg::REG_MIN_NEIGHBORS, 2);
		write_reg(dbc_pkg::REG_RADIUS, 300);
		for (int i = 0; i < 66; i++) send_point(16'(i * 64), 16'(-i * 64), i == 65);
		drain();

		// random phases
		while (points_sent < 400) begin
			write_reg(dbc_pkg::REG_MIN_NEIGHBORS,
				($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(5));
			write_reg(dbc_pkg::REG_RADIUS, ($urandom_range(5) == 0) ? $urandom
				: $urandom_range(1024));
			random_cloud(($urandom_range(9) == 0) ? 64 : $urandom_range(1, 24),
				$urandom_range(1, 600));
			drain();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
